// ----- hdl/tca_pkg.sv -----
// Shared types, constants and the rule lookup for the totalistic row stepper.
// No dependencies.
package tca_pkg;

  localparam int MaxCellsDefault = 64;
  localparam int RuleW           = 20;
  localparam int UsedLenW        = 7;
  localparam int PosW            = 6;
  localparam int ColorW          = 2;
  localparam int CfgAddrW        = 1;
  localparam int CfgDataW        = 20;
  localparam int SumW            = 4;
  localparam int MinLen          = 3;
  localparam int UsedLenReset    = 64;

  // register indexes of the configuration port
  localparam logic [CfgAddrW-1:0] CfgRuleTable  = 1'b0;
  localparam logic [CfgAddrW-1:0] CfgUsedLength = 1'b1;

  typedef enum logic {
    StIdle,
    StStep
  } tca_state_e;

  // per-cell control from the sequencer
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  // rule entry k sits at bits 2k+1..2k and serves neighborhood sum 9-k
  function automatic logic [ColorW-1:0] rule_color(logic [RuleW-1:0] rule,
                                                   logic [SumW-1:0]  sum);
    logic [ColorW-1:0] c;
    unique case (sum)
      4'd0:    c = rule[19:18];
      4'd1:    c = rule[17:16];
      4'd2:    c = rule[15:14];
      4'd3:    c = rule[13:12];
      4'd4:    c = rule[11:10];
      4'd5:    c = rule[9:8];
      4'd6:    c = rule[7:6];
      4'd7:    c = rule[5:4];
      4'd8:    c = rule[3:2];
      4'd9:    c = rule[1:0];
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ----- hdl/tca_cell.sv -----
// One cell of the row: holds a 2-bit color, loads it directly or takes the
// value of its right-hand neighbor on a shift. Depends on tca_pkg.
module tca_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tca_pkg::cell_ctrl_t         ctrl_i,
  input  logic [tca_pkg::ColorW-1:0]  load_color_i,
  input  logic [tca_pkg::ColorW-1:0]  right_i,
  output logic [tca_pkg::ColorW-1:0]  color_o
);

  logic [tca_pkg::ColorW-1:0] color_q, color_d;

  always_comb begin
    color_d = color_q;
    if (ctrl_i.shift) begin
      color_d = right_i;
    end else if (ctrl_i.load) begin
      color_d = load_color_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= '0;
    end else begin
      color_q <= color_d;
    end
  end

  assign color_o = color_q;

endmodule

// ----- hdl/totalistic_ca_row_step.sv -----
// Top level of the four-color totalistic row stepper: chain of cells plus
// step sequencer and configuration registers. Depends on tca_pkg, tca_cell.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries mode, position, cell_color.
//   A load (mode 0) writes one cell and gives no result; loads at or beyond
//   the effective length are dropped. A step (mode 1) rotates the whole
//   ring of MAX_CELLS cells once, one cell per cycle unless the receiver
//   stalls. Cell 0 of the ring is the cell being evaluated; its new color
//   goes in at the tail, so after MAX_CELLS shifts the row is back in place.
//   Each of the first L cells (L = used_length clamped to 3..MAX_CELLS) is
//   shown on the output channel (out_valid_o/out_ready_i) with its position
//   and last_of_row on cell L-1. Cells beyond L pass through unchanged.
//   The first result shows in the cycle after the step transfer. A stalled
//   receiver holds the ring still.
//   in_ready_o is low while a step runs.
//   Configuration: cfg_we_i writes register cfg_addr_i (0 rule table,
//   1 used length); write only while idle.
//   Reset: all cells zero, rule table 0, used length 64, sequencer idle.
module totalistic_ca_row_step #(
  parameter int MAX_CELLS = tca_pkg::MaxCellsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tca_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [tca_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          mode_i,
  input  logic [tca_pkg::PosW-1:0]      position_i,
  input  logic [tca_pkg::ColorW-1:0]    cell_color_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tca_pkg::PosW-1:0]      out_position_o,
  output logic [tca_pkg::ColorW-1:0]    out_color_o,
  output logic                          last_of_row_o
);

  localparam int IdxW = $clog2(MAX_CELLS);
  localparam int LenW = $clog2(MAX_CELLS + 1);
  localparam int CmpW = (LenW > tca_pkg::UsedLenW) ? LenW : tca_pkg::UsedLenW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_CELLS - 1);

  logic [tca_pkg::RuleW-1:0]    rule_q;
  logic [tca_pkg::UsedLenW-1:0] used_len_q;
  tca_pkg::tca_state_e          state_q, state_d;
  logic [IdxW-1:0]              cnt_q, cnt_d;
  logic [tca_pkg::ColorW-1:0]   prev_q, prev_d;

  logic [tca_pkg::ColorW-1:0]   colors [MAX_CELLS];
  logic [tca_pkg::ColorW-1:0]   new_color;
  logic [CmpW-1:0]              ul_ext, len, cnt_ext, pos_ext;
  logic [tca_pkg::SumW-1:0]     sum;
  logic                         in_range, edge_cell, is_last, advance, load_fire;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_q     <= '0;
      used_len_q <= tca_pkg::UsedLenW'(tca_pkg::UsedLenReset);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        tca_pkg::CfgRuleTable:  rule_q     <= cfg_wdata_i[tca_pkg::RuleW-1:0];
        tca_pkg::CfgUsedLength: used_len_q <= cfg_wdata_i[tca_pkg::UsedLenW-1:0];
        default: ;
      endcase
    end
  end

  // clamp used length to 3..MAX_CELLS
  always_comb begin
    ul_ext = CmpW'(used_len_q);
    if (ul_ext < CmpW'(tca_pkg::MinLen)) begin
      len = CmpW'(tca_pkg::MinLen);
    end else if (ul_ext > CmpW'(MAX_CELLS)) begin
      len = CmpW'(MAX_CELLS);
    end else begin
      len = ul_ext;
    end
  end

  assign cnt_ext   = CmpW'(cnt_q);
  assign pos_ext   = CmpW'(position_i);
  assign in_range  = cnt_ext < len;
  assign is_last   = cnt_ext == (len - CmpW'(1));
  assign edge_cell = (cnt_q == '0) || is_last;
  assign sum       = tca_pkg::SumW'(prev_q) + tca_pkg::SumW'(colors[0])
                   + tca_pkg::SumW'(colors[1]);

  always_comb begin
    if (!in_range) begin
      new_color = colors[0];
    end else if (edge_cell) begin
      new_color = '0;
    end else begin
      new_color = tca_pkg::rule_color(rule_q, sum);
    end
  end

  assign in_ready_o = (state_q == tca_pkg::StIdle);
  assign load_fire  = in_valid_i && in_ready_o && !mode_i && (pos_ext < len);
  assign advance    = (state_q == tca_pkg::StStep) && (!in_range || out_ready_i);

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    prev_d  = prev_q;
    unique case (state_q)
      tca_pkg::StIdle: begin
        if (in_valid_i && mode_i) begin
          state_d = tca_pkg::StStep;
          cnt_d   = '0;
          prev_d  = '0;
        end
      end
      tca_pkg::StStep: begin
        if (advance) begin
          prev_d = colors[0];
          cnt_d  = cnt_q + IdxW'(1);
          if (cnt_q == LastIdx) begin
            state_d = tca_pkg::StIdle;
          end
        end
      end
      default: state_d = tca_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tca_pkg::StIdle;
      cnt_q   <= '0;
      prev_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      prev_q  <= prev_d;
    end
  end

  // ring of cells: each takes its right neighbor, the tail takes the new color
  for (genvar j = 0; j < MAX_CELLS; j++) begin : g_cell
    tca_pkg::cell_ctrl_t       ctrl;
    logic [tca_pkg::ColorW-1:0] right;

    assign ctrl.shift = advance;
    assign ctrl.load  = load_fire && (pos_ext == CmpW'(j));

    if (j == MAX_CELLS - 1) begin : g_tail
      assign right = new_color;
    end else begin : g_body
      assign right = colors[j + 1];
    end

    tca_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .load_color_i (cell_color_i),
      .right_i      (right),
      .color_o      (colors[j])
    );
  end

  assign out_valid_o    = (state_q == tca_pkg::StStep) && in_range;
  assign out_position_o = tca_pkg::PosW'(cnt_q);
  assign out_color_o    = new_color;
  assign last_of_row_o  = is_last;

endmodule

// ----- dv/totalistic_ca_row_step_test.sv -----
// Self-checking testbench for the four-color totalistic row stepper.
// Drives loads and steps, predicts every emitted cell and compares it.
// Depends on tca_pkg and totalistic_ca_row_step.
`timescale 1ns / 1ps

module totalistic_ca_row_step_test;

  localparam int CellCount    = tca_pkg::MaxCellsDefault;
  localparam logic ModeLoad   = 1'b0;
  localparam logic ModeStep   = 1'b1;
  localparam int IdlePct      = 38;
  localparam int SettleCycles = CellCount + 16;
  localparam int RandomItems  = 385;

  typedef struct packed {
    logic [tca_pkg::PosW-1:0]   pos;
    logic [tca_pkg::ColorW-1:0] color;
    logic                       last;
  } cell_result_t;

  logic                         clk           = 1'b0;
  logic                         rst_n         = 1'b0;
  logic                         cfg_we        = 1'b0;
  logic [tca_pkg::CfgAddrW-1:0] cfg_addr      = '0;
  logic [tca_pkg::CfgDataW-1:0] cfg_wdata     = '0;
  logic                         in_valid      = 1'b0;
  logic                         in_ready;
  logic                         mode          = ModeLoad;
  logic [tca_pkg::PosW-1:0]     position      = '0;
  logic [tca_pkg::ColorW-1:0]   cell_color    = '0;
  logic                         out_valid;
  logic                         out_ready     = 1'b0;
  logic [tca_pkg::PosW-1:0]     out_position;
  logic [tca_pkg::ColorW-1:0]   out_color;
  logic                         last_of_row;

  // predictor state
  logic [tca_pkg::ColorW-1:0]   row_colors [CellCount];
  logic [tca_pkg::RuleW-1:0]    rule_bits;
  logic [tca_pkg::UsedLenW-1:0] row_length_reg;
  cell_result_t                 pending_cells [$];

  int error_count = 0;
  bit no_gaps     = 1'b0;
  int rx_hold_req = 0;

  totalistic_ca_row_step uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_addr_i     (cfg_addr),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .mode_i         (mode),
    .position_i     (position),
    .cell_color_i   (cell_color),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .out_position_o (out_position),
    .out_color_o    (out_color),
    .last_of_row_o  (last_of_row)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int active_length();
    int n;
    n = int'(row_length_reg);
    if (n < tca_pkg::MinLen) n = tca_pkg::MinLen;
    if (n > CellCount) n = CellCount;
    return n;
  endfunction

  // Apply one accepted item to the row copy and queue the cells it emits.
  function automatic void advance_row_model(logic m, logic [tca_pkg::PosW-1:0] p,
                                            logic [tca_pkg::ColorW-1:0] c);
    int n;
    int i;
    int sum;
    logic [tca_pkg::ColorW-1:0] next_gen [CellCount];
    cell_result_t r;
    n = active_length();
    if (m == ModeLoad) begin
      if (int'(p) < n) row_colors[p] = c;
      return;
    end
    next_gen[0] = '0;
    for (i = 1; i < n - 1; i++) begin
      sum = int'(row_colors[i-1]) + int'(row_colors[i]) + int'(row_colors[i+1]);
      next_gen[i] = rule_bits[2*(9-sum) +: 2];
    end
    next_gen[n-1] = '0;
    for (i = 0; i < n; i++) begin
      row_colors[i] = next_gen[i];
      r.pos   = i[tca_pkg::PosW-1:0];
      r.color = next_gen[i];
      r.last  = (i == n - 1);
      pending_cells = {pending_cells, r};
    end
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    cell_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_cells.size() == 0) begin
        $display("%0t: unexpected cell, expected none, actual pos %0d color %0d last %0d",
                 $time, out_position, out_color, last_of_row);
        error_count++;
      end else begin
        want = pending_cells.pop_front();
        check_field("out_position", 8'(want.pos), 8'(out_position));
        check_field("out_color", 8'(want.color), 8'(out_color));
        check_field("last_of_row", 8'(want.last), 8'(last_of_row));
      end
    end
  end

  // receiver: random stalls, always ready when no_gaps is set, or a counted hold-off when one is requested
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_req > 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (no_gaps) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= IdlePct);
      end
    end
  end

  task automatic send_cell_item(logic m, logic [tca_pkg::PosW-1:0] p,
                                logic [tca_pkg::ColorW-1:0] c);
    if (!no_gaps) begin
      while ($urandom_range(99) < IdlePct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid   <= 1'b1;
    mode       <= m;
    position   <= p;
    cell_color <= c;
    do @(posedge clk); while (!in_ready);
    advance_row_model(m, p, c);
  endtask

  task automatic load_cell(int p, int c);
    send_cell_item(ModeLoad, p[tca_pkg::PosW-1:0], c[tca_pkg::ColorW-1:0]);
  endtask

  // position and color are don't-cares on a step; randomize them anyway
  task automatic step_row();
    send_cell_item(ModeStep, tca_pkg::PosW'($urandom_range(0, 63)),
                   tca_pkg::ColorW'($urandom_range(0, 3)));
  endtask

  task automatic write_register(logic [tca_pkg::CfgAddrW-1:0] addr, int data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data[tca_pkg::CfgDataW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (addr == tca_pkg::CfgRuleTable) rule_bits = data[tca_pkg::RuleW-1:0];
    else row_length_reg = data[tca_pkg::UsedLenW-1:0];
    @(posedge clk);
  endtask

  // Drop valid, wait for every cell, then let the ring finish its rotation.
  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic test_reset_row();
    step_row();
    wait_results_done();
  endtask

  task automatic test_length_clamp();
    int i;
    write_register(tca_pkg::CfgRuleTable, 20'hFFFFF);
    write_register(tca_pkg::CfgUsedLength, tca_pkg::MinLen);
    for (i = 0; i < 3; i++) load_cell(i, 3);
    load_cell(3, 2);   // out of range, drop
    load_cell(63, 1);  // out of range, drop
    step_row();
    wait_results_done();
    write_register(tca_pkg::CfgUsedLength, 0);
    step_row();
    wait_results_done();
    write_register(tca_pkg::CfgUsedLength, 127);
    load_cell(63, 3);
    load_cell(62, 2);
    step_row();
    wait_results_done();
  endtask

  task automatic test_rule_entries();
    int i;
    write_register(tca_pkg::CfgRuleTable, 20'h1B4E7);
    write_register(tca_pkg::CfgUsedLength, 12);
    for (i = 0; i < 6; i++) load_cell(i, $urandom_range(0, 3));
    step_row();
    step_row();
    wait_results_done();
  endtask

  task automatic test_cells_beyond_length();
    write_register(tca_pkg::CfgUsedLength, 64);
    load_cell(40, 2);
    load_cell(63, 1);
    wait_results_done();
    write_register(tca_pkg::CfgUsedLength, 10);
    step_row();
    wait_results_done();
    write_register(tca_pkg::CfgUsedLength, 64);
    step_row();
    wait_results_done();
  endtask

  // hold the output long enough that the ring stalls and input backs up
  task automatic test_output_stall();
    write_register(tca_pkg::CfgRuleTable, $urandom_range(0, 20'hFFFFF));
    rx_hold_req = 400;
    repeat (3) step_row();
    wait_results_done();
  endtask

  task automatic test_random_generations();
    int counted;
    int phase;
    int gens;
    int loads;
    int n;
    int p;
    counted = 0;
    phase   = 0;
    while (counted < RandomItems) begin
      write_register(tca_pkg::CfgRuleTable, $urandom_range(0, 20'hFFFFF));
      case ($urandom_range(0, 5))
        0:       write_register(tca_pkg::CfgUsedLength, $urandom_range(0, 2));
        1:       write_register(tca_pkg::CfgUsedLength, tca_pkg::MinLen);
        2:       write_register(tca_pkg::CfgUsedLength, 64);
        3:       write_register(tca_pkg::CfgUsedLength, $urandom_range(65, 127));
        4:       write_register(tca_pkg::CfgUsedLength, $urandom_range(3, 64));
        default: write_register(tca_pkg::CfgUsedLength, $urandom_range(4, 20));
      endcase
      no_gaps = (phase == 2);
      n = active_length();
      gens = $urandom_range(1, 4);
      repeat (gens) begin
        loads = $urandom_range(0, 8);
        repeat (loads) begin
          if ($urandom_range(99) < 85) p = $urandom_range(0, n - 1);
          else p = $urandom_range(0, 63);
          load_cell(p, $urandom_range(0, 3));
          if (p < n) counted++;
        end
        // now and then leave a generation without its step
        if ($urandom_range(99) >= 10) begin
          step_row();
          counted++;
        end
      end
      wait_results_done();
      no_gaps = 1'b0;
      phase++;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    rule_bits      = '0;
    row_length_reg = tca_pkg::UsedLenW'(tca_pkg::UsedLenReset);
    foreach (row_colors[i]) row_colors[i] = '0;
    @(posedge clk);

    test_reset_row();
    test_length_clamp();
    test_rule_entries();
    test_cells_beyond_length();
    test_output_stall();
    test_random_generations();

    wait_results_done();
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/tca_pkg.sv
hdl/tca_cell.sv
hdl/totalistic_ca_row_step.sv
dv/totalistic_ca_row_step_test.sv
